### hdl/ptl_pkg.sv
// Package for the perturbation table lookup block.
// Holds the table size, field widths, request opcodes and the stored record type.
// No dependencies.
package ptl_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int CAT_W = 32;
    localparam int KEY_W = 33;
    localparam int VAL_W = 16;

    // Request opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic [CAT_W-1:0]        cat;
        logic [KEY_W-1:0]        lo;
        logic [KEY_W-1:0]        hi;
        logic signed [VAL_W-1:0] val;
    } rec_t;

endpackage

### hdl/ptl_mod_unit.sv
// Iterative remainder unit: dividend % divisor, one quotient bit per cycle.
// Depends on ptl_pkg.
module ptl_mod_unit
    import ptl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CAT_W-1:0] dividend,
    input  logic [CAT_W:0]   divisor,
    output logic             done,
    output logic [CAT_W-1:0] remainder
);

    localparam int STEP_W = $clog2(CAT_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CAT_W-1:0]  dvd_reg;
    logic [CAT_W:0]    dvs_reg;
    logic [CAT_W-1:0]  rem_reg;
    logic [CAT_W-1:0]  rem_next;

    // Restoring step: remainder stays below divisor, so it fits CAT_W bits.
    always_comb
    begin
        logic [CAT_W:0] shifted;
        logic [CAT_W:0] diff;
        shifted  = {rem_reg, dvd_reg[CAT_W-1]};
        diff     = shifted - dvs_reg;
        if (shifted >= dvs_reg)
        begin
            rem_next = diff[CAT_W-1:0];
        end
        else
        begin
            rem_next = shifted[CAT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                done_reg <= (step_reg == STEP_W'(CAT_W - 1));
                if (step_reg == STEP_W'(CAT_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[CAT_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

### hdl/ptl_store.sv
// Record store: one write port, one read port, registered read data.
// Depends on ptl_pkg.
module ptl_store
    import ptl_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  rec_t              wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output rec_t              rd_data
);

    rec_t mem [TABLE_DEPTH];
    rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/perturbation_table_lookup.sv
// Perturbation table lookup. An insert request appends a record to the
// store and raises the maximum category if its category is larger; into a
// full store it is dropped and sets the sticky overflow flag. A lookup
// request is served by a linear scan of the store that reads one record per
// cycle through its single read port. When the category exceeds the maximum
// category, the bit-serial remainder unit first reduces it modulo the
// maximum category plus one. One request is worked at a time; the result
// sits in an output register, so the next request is taken while a result
// still waits.
module perturbation_table_lookup
    import ptl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  logic                    operation,
    input  logic [CAT_W-1:0]        category,
    input  logic [KEY_W-1:0]        lower_bound,
    input  logic [KEY_W-1:0]        upper_bound,
    input  logic signed [VAL_W-1:0] perturbation,
    input  logic [KEY_W-1:0]        cell_key,
    output logic                    res_valid,
    input  logic                    res_stall,
    output logic signed [VAL_W-1:0] noise_value,
    output logic                    found,
    output logic                    overflowed
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CAT_W-1:0]        max_reg;
    logic                    ovf_reg;
    logic [CAT_W-1:0]        idx_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [CNT_W-1:0]        issue_reg;
    logic                    chk_reg;
    logic signed [VAL_W-1:0] hit_val_reg;
    logic                    hit_reg;
    logic                    res_valid_reg;
    logic signed [VAL_W-1:0] res_val_reg;
    logic                    res_found_reg;
    logic                    res_ovf_reg;

    logic   accept;
    logic   do_insert;
    logic   full;
    logic   div_start;
    logic   div_done;
    logic [CAT_W-1:0] div_rem;
    logic   rd_en;
    rec_t   wr_rec;
    rec_t   rd_rec;
    logic   rec_match;
    logic   out_free;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg == CNT_W'(TABLE_DEPTH));
    assign do_insert = accept && (operation == OP_INSERT) && !full;
    assign div_start = accept && (operation == OP_LOOKUP) && (category > max_reg);

    // Scan issues one read per cycle while records remain.
    assign rd_en = (state_reg == S_SCAN) && !rec_match && (issue_reg < count_reg);

    // The record read in the previous cycle is compared here.
    assign rec_match = chk_reg && (rd_rec.cat == idx_reg) &&
                       (rd_rec.lo <= key_reg) && (rd_rec.hi >= key_reg);

    // Output register is free when empty or being drained this cycle.
    assign out_free = !res_valid_reg || !res_stall;

    assign wr_rec.cat = category;
    assign wr_rec.lo  = lower_bound;
    assign wr_rec.hi  = upper_bound;
    assign wr_rec.val = perturbation;

    ptl_store u_store (
        .clk     (clk),
        .wr_en   (do_insert),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (wr_rec),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[ADDR_W-1:0]),
        .rd_data (rd_rec)
    );

    // Divisor is max + 1, which needs one extra bit.
    ptl_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (category),
        .divisor   ({1'b0, max_reg} + 1'b1),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            max_reg       <= '0;
            ovf_reg       <= 1'b0;
            issue_reg     <= '0;
            chk_reg       <= 1'b0;
            hit_reg       <= 1'b0;
            hit_val_reg   <= '0;
            res_valid_reg <= 1'b0;
            res_val_reg   <= '0;
            res_found_reg <= 1'b0;
            res_ovf_reg   <= 1'b0;
            idx_reg       <= '0;
            key_reg       <= '0;
        end
        else
        begin
            // In S_DONE the output register is reloaded below instead.
            if (res_valid_reg && !res_stall && (state_reg != S_DONE))
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (operation == OP_INSERT)
                        begin
                            if (full)
                            begin
                                ovf_reg <= 1'b1;
                            end
                            else
                            begin
                                count_reg <= count_reg + 1'b1;
                                if (category > max_reg)
                                begin
                                    max_reg <= category;
                                end
                            end
                        end
                        else
                        begin
                            key_reg   <= cell_key;
                            idx_reg   <= category;
                            issue_reg <= '0;
                            chk_reg   <= 1'b0;
                            state_reg <= div_start ? S_MOD : S_SCAN;
                        end
                    end
                end

                S_MOD:
                begin
                    if (div_done)
                    begin
                        idx_reg   <= div_rem;
                        state_reg <= S_SCAN;
                    end
                end

                S_SCAN:
                begin
                    if (rec_match)
                    begin
                        hit_reg     <= 1'b1;
                        hit_val_reg <= rd_rec.val;
                        chk_reg     <= 1'b0;
                        state_reg   <= S_DONE;
                    end
                    else if (rd_en)
                    begin
                        issue_reg <= issue_reg + 1'b1;
                        chk_reg   <= 1'b1;
                    end
                    else
                    begin
                        // Last record checked without a match.
                        hit_reg     <= 1'b0;
                        hit_val_reg <= '0;
                        chk_reg     <= 1'b0;
                        state_reg   <= S_DONE;
                    end
                end

                S_DONE:
                begin
                    if (out_free)
                    begin
                        res_valid_reg <= 1'b1;
                        res_val_reg   <= hit_val_reg;
                        res_found_reg <= hit_reg;
                        res_ovf_reg   <= ovf_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_valid   = res_valid_reg;
    assign noise_value = res_val_reg;
    assign found       = res_found_reg;
    assign overflowed  = res_ovf_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("record count above table depth");

    a_read_written: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (issue_reg < count_reg))
        else $error("scan reads an entry never written");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !found) |-> (noise_value == '0))
        else $error("miss carries a nonzero value");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag cleared");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (operation == OP_INSERT) && full) |=> ($stable(count_reg) && ovf_reg))
        else $error("insert into full store not dropped");
`endif

endmodule
